// File: src/rhsv_pkg.sv
// Package for the 8-bit RGB to HSV converter: field widths, the hue sector
// code and the payload structs that pass between the pipeline sections.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rhsv_pkg;

    localparam int CH_W   = 8;   // one colour channel
    localparam int Q_W    = 8;   // quotient bits, one divider stage each
    localparam int NUM_W  = 11;  // hue sector numerator, below 6 * 255
    localparam int HNUM_W = 19;  // 255 times the hue numerator
    localparam int HDEN_W = 11;  // 6 times delta
    localparam int SNUM_W = 16;  // 255 times delta

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        logic [HNUM_W-1:0] hue_num;
        logic [HDEN_W-1:0] hue_den;
        logic [SNUM_W-1:0] sat_num;
        logic [CH_W-1:0]   sat_den;
        logic [CH_W-1:0]   max_val;
        logic              grey;
    } t_div_in;

    typedef struct packed {
        logic [HNUM_W-1:0] hue_rem;
        logic [HDEN_W-1:0] hue_den;
        logic [Q_W-1:0]    hue_q;
        logic [SNUM_W-1:0] sat_rem;
        logic [CH_W-1:0]   sat_den;
        logic [Q_W-1:0]    sat_q;
        logic [CH_W-1:0]   max_val;
        logic              grey;
    } t_div_stage;

    typedef struct packed {
        logic [Q_W-1:0]  hue_q;
        logic [Q_W-1:0]  sat_q;
        logic [CH_W-1:0] max_val;
        logic            grey;
    } t_div_out;

endpackage

`default_nettype wire

// File: src/rhsv_front.sv
// Front section of the converter: max/min search in the first stage, then
// delta, hue sector numerator and the scaled dividends and divisors.
// Depends on rhsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhsv_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [7:0]           i_red,
    input  wire logic [7:0]           i_green,
    input  wire logic [7:0]           i_blue,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output rhsv_pkg::t_div_in         o_data
);
    import rhsv_pkg::*;

    logic            r_a_v;
    logic [CH_W-1:0] r_a_r, r_a_g, r_a_b, r_a_mx, r_a_mn;
    t_sector         r_a_sel;
    logic            r_b_v;
    t_div_in         r_b_data;

    logic            en_a, en_b;
    logic [CH_W-1:0] n_mx, n_mn, n_d;
    t_sector         n_sel;
    logic [NUM_W-1:0] n_d11, n_num;
    t_div_in         n_b_data;

    assign en_b    = !r_b_v || i_ready;
    assign en_a    = !r_a_v || en_b;
    assign o_ready = en_a;
    assign o_valid = r_b_v;
    assign o_data  = r_b_data;

    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n_sel = SEC_RED;
            n_mx  = i_red;
        end else if (i_green >= i_blue) begin
            n_sel = SEC_GREEN;
            n_mx  = i_green;
        end else begin
            n_sel = SEC_BLUE;
            n_mx  = i_blue;
        end
        n_mn = i_red;
        if (i_green < n_mn) begin
            n_mn = i_green;
        end
        if (i_blue < n_mn) begin
            n_mn = i_blue;
        end
    end

    always_comb begin
        n_d   = r_a_mx - r_a_mn;
        n_d11 = NUM_W'(n_d);
        unique case (r_a_sel)
            SEC_RED: begin
                if (r_a_g >= r_a_b) begin
                    n_num = NUM_W'(r_a_g) - NUM_W'(r_a_b);
                end else begin
                    n_num = (n_d11 << 2) + (n_d11 << 1) - (NUM_W'(r_a_b) - NUM_W'(r_a_g));
                end
            end
            SEC_GREEN: begin
                n_num = (n_d11 << 1) + NUM_W'(r_a_b) - NUM_W'(r_a_r);
            end
            SEC_BLUE: begin
                n_num = (n_d11 << 2) + NUM_W'(r_a_r) - NUM_W'(r_a_g);
            end
            default: begin
                n_num = '0;
            end
        endcase
        n_b_data.hue_num = {n_num, 8'b0} - HNUM_W'(n_num);
        n_b_data.hue_den = (HDEN_W'(n_d) << 2) + (HDEN_W'(n_d) << 1);
        n_b_data.sat_num = {n_d, 8'b0} - SNUM_W'(n_d);
        n_b_data.sat_den = r_a_mx;
        n_b_data.max_val = r_a_mx;
        n_b_data.grey    = (n_d == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_v <= i_valid;
            end
            if (en_b) begin
                r_b_v <= r_a_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_r   <= i_red;
            r_a_g   <= i_green;
            r_a_b   <= i_blue;
            r_a_mx  <= n_mx;
            r_a_mn  <= n_mn;
            r_a_sel <= n_sel;
        end
        if (en_b) begin
            r_b_data <= n_b_data;
        end
    end

endmodule

`default_nettype wire

// File: src/rhsv_div.sv
// Pipelined restoring divider for hue and saturation side by side: one
// quotient bit per register stage, eight stages. Depends on rhsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhsv_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire rhsv_pkg::t_div_in    i_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output rhsv_pkg::t_div_out        o_data
);
    import rhsv_pkg::*;

    logic       r_v  [0:Q_W-1];
    t_div_stage r_st [0:Q_W-1];
    t_div_stage cur_st [0:Q_W-1];
    t_div_stage n_st   [0:Q_W-1];
    logic       cur_v  [0:Q_W-1];
    logic       en     [0:Q_W-1];

    genvar k;
    generate
        for (k = 0; k < Q_W; k++) begin : g_stage
            localparam int SH = Q_W - 1 - k;
            logic [HNUM_W-1:0] hden_sh;
            logic [SNUM_W-1:0] sden_sh;
            logic              hue_ge, sat_ge;

            if (k == 0) begin : g_first
                assign cur_v[k]          = i_valid;
                assign cur_st[k].hue_rem = i_data.hue_num;
                assign cur_st[k].hue_den = i_data.hue_den;
                assign cur_st[k].hue_q   = '0;
                assign cur_st[k].sat_rem = i_data.sat_num;
                assign cur_st[k].sat_den = i_data.sat_den;
                assign cur_st[k].sat_q   = '0;
                assign cur_st[k].max_val = i_data.max_val;
                assign cur_st[k].grey    = i_data.grey;
            end else begin : g_next
                assign cur_v[k]  = r_v[k-1];
                assign cur_st[k] = r_st[k-1];
            end

            if (k == Q_W - 1) begin : g_last_en
                assign en[k] = !r_v[k] || i_ready;
            end else begin : g_mid_en
                assign en[k] = !r_v[k] || en[k+1];
            end

            assign hden_sh = HNUM_W'(cur_st[k].hue_den) << SH;
            assign sden_sh = SNUM_W'(cur_st[k].sat_den) << SH;
            assign hue_ge  = cur_st[k].hue_rem >= hden_sh;
            assign sat_ge  = cur_st[k].sat_rem >= sden_sh;

            assign n_st[k].hue_rem = hue_ge ? cur_st[k].hue_rem - hden_sh
                                            : cur_st[k].hue_rem;
            assign n_st[k].hue_den = cur_st[k].hue_den;
            assign n_st[k].hue_q   = {cur_st[k].hue_q[Q_W-2:0], hue_ge};
            assign n_st[k].sat_rem = sat_ge ? cur_st[k].sat_rem - sden_sh
                                            : cur_st[k].sat_rem;
            assign n_st[k].sat_den = cur_st[k].sat_den;
            assign n_st[k].sat_q   = {cur_st[k].sat_q[Q_W-2:0], sat_ge};
            assign n_st[k].max_val = cur_st[k].max_val;
            assign n_st[k].grey    = cur_st[k].grey;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (en[k]) begin
                    r_v[k] <= cur_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_st[k] <= n_st[k];
                end
            end
        end
    endgenerate

    assign o_ready        = en[0];
    assign o_valid        = r_v[Q_W-1];
    assign o_data.hue_q   = r_st[Q_W-1].hue_q;
    assign o_data.sat_q   = r_st[Q_W-1].sat_q;
    assign o_data.max_val = r_st[Q_W-1].max_val;
    assign o_data.grey    = r_st[Q_W-1].grey;

endmodule

`default_nettype wire

// File: src/rgb_to_hsv_8bit.sv
// Top level of the 8-bit RGB to HSV converter with stream ports.
// Depends on rhsv_pkg, rhsv_front and rhsv_div.
//
// One pixel is accepted in every cycle unless the pipeline is full and the
// output stalled. Each result passes two front stages that find max, min and
// the scaled sector numerator, an eight-stage divider that yields one
// quotient bit per stage for hue and for saturation in parallel, and an
// output register that holds the result. Every stage has its own valid bit,
// so a stalled output fills the pipeline bubble by bubble while new pixels
// are still taken. Black and grey pixels give zero hue and saturation.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_8bit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata    // hue [7:0], saturation [15:8], brightness [23:16]
);
    import rhsv_pkg::*;

    logic     front_v, front_rdy, div_v, div_rdy;
    t_div_in  front_data;
    t_div_out div_data;
    logic     r_out_v;
    logic [23:0] r_out_data;
    logic [23:0] n_out_data;

    rhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_red   (i_s_axis_tdata[7:0]),
        .i_green (i_s_axis_tdata[15:8]),
        .i_blue  (i_s_axis_tdata[23:16]),
        .o_valid (front_v),
        .i_ready (front_rdy),
        .o_data  (front_data)
    );

    rhsv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_v),
        .o_ready (front_rdy),
        .i_data  (front_data),
        .o_valid (div_v),
        .i_ready (div_rdy),
        .o_data  (div_data)
    );

    assign div_rdy = !r_out_v || i_m_axis_tready;

    always_comb begin
        n_out_data[7:0]   = div_data.grey ? '0 : div_data.hue_q;
        n_out_data[15:8]  = div_data.grey ? '0 : div_data.sat_q;
        n_out_data[23:16] = div_data.max_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (div_rdy) begin
            r_out_v <= div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_rdy) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the 8-bit RGB to HSV converter, rgb_to_hsv_8bit.
// Depends on rhsv_pkg for channel widths and hue sector codes, and on the converter itself.
// Directed and random pixels are compared against a predictor, with random stalls on both streams.
`timescale 1ns / 1ps

module testbench;
    import rhsv_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_rgb;

    typedef struct packed {
        logic [CH_W-1:0] brightness;
        logic [CH_W-1:0] saturation;
        logic [CH_W-1:0] hue;
    } t_hsv;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        logic            typed;
        logic [CH_W-1:0] h;
        logic [CH_W-1:0] s;
        logic [CH_W-1:0] v;
    } t_probe;

    localparam int NPROBE      = 24;
    localparam int N_RANDOM    = 1630;
    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_WAIT  = 30;
    localparam int MAX_REPORTS = 10;

    localparam t_probe PROBES [NPROBE] = '{
        '{0, 0, 0, 1, 0, 0, 0},
        '{1, 1, 1, 1, 0, 0, 1},
        '{128, 128, 128, 1, 0, 0, 128},
        '{255, 255, 255, 1, 0, 0, 255},
        '{255, 0, 0, 1, 0, 255, 255},
        '{0, 255, 0, 1, 85, 255, 255},
        '{0, 0, 255, 1, 170, 255, 255},
        '{1, 0, 0, 1, 0, 255, 1},
        '{0, 1, 0, 0, 0, 0, 0},
        '{0, 0, 1, 0, 0, 0, 0},
        '{255, 0, 1, 0, 0, 0, 0},
        '{200, 10, 100, 0, 0, 0, 0},
        '{255, 1, 254, 0, 0, 0, 0},
        '{255, 255, 0, 0, 0, 0, 0},
        '{255, 0, 255, 0, 0, 0, 0},
        '{0, 255, 255, 0, 0, 0, 0},
        '{100, 255, 0, 0, 0, 0, 0},
        '{0, 255, 100, 0, 0, 0, 0},
        '{100, 0, 255, 0, 0, 0, 0},
        '{0, 100, 255, 0, 0, 0, 0},
        '{254, 255, 255, 0, 0, 0, 0},
        '{255, 254, 254, 0, 0, 0, 0},
        '{128, 127, 127, 0, 0, 0, 0},
        '{1, 255, 128, 0, 0, 0, 0}
    };

    logic i_clk    = 1'b0;
    logic rst_n    = 1'b0;
    logic s_tvalid = 1'b0;
    t_rgb s_tdata  = '0;
    logic m_tready = 1'b0;
    logic o_s_axis_tready;
    logic o_m_axis_tvalid;
    t_hsv m_tdata;

    logic drv_typed = 1'b0;
    t_hsv drv_hsv   = '0;

    t_hsv hsv_due [$];
    t_hsv want;
    int   fails       = 0;
    int   idle_cycles = 0;
    bit   gapless     = 1'b0;
    int   hold_ask    = 0;
    int   hold_seen   = 0;
    int   hold_left   = 0;
    int   run_left    = 0;
    int   pick;

    rgb_to_hsv_8bit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_hsv hsv_of(t_rgb px);
        int unsigned r, g, b, mx, mn, d, num;
        t_sector     sec;
        t_hsv        res;
        r = px.red;
        g = px.green;
        b = px.blue;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        res = '0;
        res.brightness = CH_W'(mx);
        if (d != 0) begin
            res.saturation = CH_W'((255 * d) / mx);
            if (r == mx) begin
                sec = SEC_RED;
            end else if (g == mx) begin
                sec = SEC_GREEN;
            end else begin
                sec = SEC_BLUE;
            end
            case (sec)
                SEC_RED: begin
                    num = (g >= b) ? g - b : 6 * d - (b - g);
                end
                SEC_GREEN: begin
                    num = 2 * d + b - r;
                end
                default: begin
                    num = 4 * d + r - g;
                end
            endcase
            res.hue = CH_W'((255 * num) / (6 * d));
        end
        return res;
    endfunction

    function automatic logic [CH_W-1:0] extreme_level();
        logic [CH_W-1:0] lvl;
        case ($urandom_range(0, 3))
            0: lvl = 8'd0;
            1: lvl = 8'd1;
            2: lvl = 8'd254;
            default: lvl = 8'd255;
        endcase
        return lvl;
    endfunction

    function automatic logic [CH_W-1:0] near_level(int base);
        int lvl;
        lvl = base + int'($urandom_range(0, 4)) - 2;
        if (lvl < 0) lvl = 0;
        if (lvl > 255) lvl = 255;
        return CH_W'(lvl);
    endfunction

    function automatic t_rgb random_pixel();
        t_rgb px;
        int   kind, v, lo;
        kind = $urandom_range(0, 99);
        px.red   = CH_W'($urandom_range(0, 255));
        px.green = CH_W'($urandom_range(0, 255));
        px.blue  = CH_W'($urandom_range(0, 255));
        if (kind < 55) begin
            return px;
        end else if (kind < 65) begin
            v = $urandom_range(0, 255);
            px = '{CH_W'(v), CH_W'(v), CH_W'(v)};
        end else if (kind < 75) begin
            v  = $urandom_range(1, 255);
            lo = $urandom_range(0, v - 1);
            case ($urandom_range(0, 2))
                0: px = '{CH_W'(lo), CH_W'(v), CH_W'(v)};
                1: px = '{CH_W'(v), CH_W'(lo), CH_W'(v)};
                default: px = '{CH_W'(v), CH_W'(v), CH_W'(lo)};
            endcase
        end else if (kind < 83) begin
            px = '{extreme_level(), extreme_level(), extreme_level()};
        end else if (kind < 92) begin
            v = $urandom_range(0, 255);
            px = '{near_level(v), near_level(v), near_level(v)};
        end else begin
            case ($urandom_range(0, 2))
                0: px.red = '0;
                1: px.green = '0;
                default: px.blue = '0;
            endcase
        end
        return px;
    endfunction

    function automatic int sender_gap();
        int p;
        if (gapless) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Offers one pixel and returns just after the edge at which it is accepted.
    task automatic send_pixel(t_rgb px, logic typed, t_hsv hsv);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= px;
        drv_typed <= typed;
        drv_hsv   <= hsv;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (hsv_due.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic note_fail(string what, t_hsv exp_hsv, t_hsv got_hsv);
        fails++;
        if (fails <= MAX_REPORTS) begin
            $display("%s: expected h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d", what,
                     exp_hsv.hue, exp_hsv.saturation, exp_hsv.brightness,
                     got_hsv.hue, got_hsv.saturation, got_hsv.brightness);
        end
    endtask

    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            run_left <= 0;
        end else if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (run_left != 0) begin
            run_left <= run_left - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                m_tready <= 1'b1;
                run_left <= $urandom_range(20, 80);
            end else if (pick < 90) begin
                m_tready <= ($urandom_range(0, 3) != 0);
                run_left <= $urandom_range(0, 3);
            end else if (pick < 97) begin
                m_tready <= 1'b0;
                run_left <= $urandom_range(4, 12);
            end else begin
                m_tready <= 1'b0;
                run_left <= $urandom_range(20, 60);
            end
        end
    end

    // Records each accepted pixel, then checks each result transaction in order.
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (s_tvalid && o_s_axis_tready) begin
                hsv_due.push_back(drv_typed ? drv_hsv : hsv_of(s_tdata));
            end
            if (o_m_axis_tvalid && m_tready) begin
                if (hsv_due.size() == 0) begin
                    note_fail("unexpected result", '0, m_tdata);
                end else begin
                    want = hsv_due.pop_front();
                    if (want.hue != m_tdata.hue || want.saturation != m_tdata.saturation
                            || want.brightness != m_tdata.brightness) begin
                        note_fail("mismatch", want, m_tdata);
                    end
                end
            end
            if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < NPROBE; i++) begin
            send_pixel('{PROBES[i].b, PROBES[i].g, PROBES[i].r}, PROBES[i].typed,
                       '{PROBES[i].v, PROBES[i].s, PROBES[i].h});
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            gapless = (i >= 300 && i < 500) || (i % 200 >= 150);
            if (i == 300) hold_ask <= hold_ask + 1;
            if (i == 800 || i == 1400) drain_results();
            send_pixel(random_pixel(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        while (hsv_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
src/rhsv_pkg.sv
src/rhsv_front.sv
src/rhsv_div.sv
src/rgb_to_hsv_8bit.sv
tb/sv/testbench.sv
